// ----- design/utf8_code_point_decoder_core_defines.svh -----
// Assertion macros shared by the decoder modules.
`ifndef UTF8_CODE_POINT_DECODER_CORE_DEFINES_SVH
`define UTF8_CODE_POINT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define UTFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define UTFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/utfd_pkg.sv -----
package utfd_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] REPL_CP     = 21'h00FFFD;
  localparam logic [7:0]      LEAD_MIN    = 8'hC2;
  localparam logic [7:0]      LEAD_MAX    = 8'hF4;
  localparam logic [7:0]      LEAD3_FIRST = 8'hE0;
  localparam logic [7:0]      LEAD4_FIRST = 8'hF0;

  // What closes a job after its flushed replacements.
  typedef enum logic [1:0] {
    FK_NONE,
    FK_CP,
    FK_ERR,
    FK_EOS
  } final_kind_t;

  typedef struct packed {
    logic [1:0]      flush_cnt;
    final_kind_t     kind;
    logic [CP_W-1:0] cp;
  } utfd_job_t;

endpackage

// ----- design/utf8_code_point_decoder_core.sv -----
// Channel  | Direction | Handshake                  | Payload
// byte     | in        | byte_valid / byte_ready    | in_byte
// result   | out       | result_valid / result_ready| code_point, decode_error,
//          |           |                            | end_of_string, last_in_run
// cfg      | in        | cfg_valid / cfg_ready      | bmp_only
//
// One byte per cycle is taken while the job queue has room; the queue holds
// QueueDepth jobs. Each result is one transfer on the result channel, so a
// byte with k results holds the back end until all k have been taken. The
// first result of a byte passes through the job queue and then the back end's
// current-job register. Reset is synchronous, clears the decode state and
// queue, and sets bmp_only to 1. cfg_ready is always high. A stalled result
// channel fills the queue, then drops byte_ready.
module utf8_code_point_decoder_core
  import utfd_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            bmp_only,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      in_byte,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [CP_W-1:0] code_point,
  output logic            decode_error,
  output logic            end_of_string,
  output logic            last_in_run
);

  logic      push;
  utfd_job_t push_job;
  logic      full;
  logic      pop;
  utfd_job_t pop_job;
  logic      empty;

  assign cfg_ready  = 1'b1;
  assign byte_ready = !full;

  utfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (bmp_only),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .in_byte    (in_byte),
    .push       (push),
    .push_job   (push_job)
  );

  utfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  utfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .pop_job       (pop_job),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .code_point    (code_point),
    .decode_error  (decode_error),
    .end_of_string (end_of_string),
    .last_in_run   (last_in_run)
  );

endmodule

// ----- design/utfd_front.sv -----
module utfd_front
  import utfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr,
  input  logic      cfg_data,
  input  logic      byte_valid,
  input  logic      byte_ready,
  input  logic [7:0] in_byte,
  output logic      push,
  output utfd_job_t push_job
);

  logic       bmp_only;
  logic [7:0] held_lead;
  logic [7:0] held_cont [2];
  logic [1:0] held_count;
  logic       seq_active;

  logic [7:0] held_lead_next;
  logic [1:0] held_count_next;
  logic       seq_active_next;
  logic       cont_wr;

  logic        take;
  logic        is_cont;
  logic        fresh_open;
  final_kind_t fresh_kind;
  logic [1:0]  need;
  logic        complete;
  logic [CP_W-1:0] raw_cp;
  logic [CP_W-1:0] seq_cp;
  utfd_job_t   job;

  assign take    = byte_valid && byte_ready;
  assign is_cont = (in_byte[7:6] == 2'b10);

  always_comb begin
    fresh_open = 1'b0;
    fresh_kind = FK_ERR;
    if (!in_byte[7]) begin
      fresh_kind = FK_CP;
    end else if (in_byte >= LEAD_MIN && in_byte <= LEAD_MAX) begin
      fresh_open = 1'b1;
      fresh_kind = FK_NONE;
    end
  end

  always_comb begin
    if (held_lead < LEAD3_FIRST) begin
      need = 2'd1;
    end else if (held_lead < LEAD4_FIRST) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
  end

  assign complete = ({1'b0, held_count} + 3'd1) >= {1'b0, need};

  always_comb begin
    unique case (need)
      2'd1:    raw_cp = {10'd0, held_lead[4:0], in_byte[5:0]};
      2'd2:    raw_cp = {5'd0, held_lead[3:0], held_cont[0][5:0], in_byte[5:0]};
      default: raw_cp = {held_lead[2:0], held_cont[0][5:0], held_cont[1][5:0],
                         in_byte[5:0]};
    endcase
  end

  assign seq_cp = (bmp_only && raw_cp[CP_W-1:16] != '0) ? REPL_CP : raw_cp;

  always_comb begin
    job             = '0;
    job.kind        = FK_NONE;
    held_lead_next  = held_lead;
    held_count_next = held_count;
    seq_active_next = seq_active;
    cont_wr         = 1'b0;
    if (in_byte == 8'd0) begin
      job.flush_cnt   = seq_active ? 2'(held_count + 2'd1) : 2'd0;
      job.kind        = FK_EOS;
      job.cp          = '0;
      held_lead_next  = '0;
      held_count_next = '0;
      seq_active_next = 1'b0;
    end else if (seq_active && is_cont) begin
      if (complete) begin
        job.kind        = FK_CP;
        job.cp          = seq_cp;
        held_lead_next  = '0;
        held_count_next = '0;
        seq_active_next = 1'b0;
      end else begin
        cont_wr         = 1'b1;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      job.flush_cnt = seq_active ? 2'(held_count + 2'd1) : 2'd0;
      job.kind      = fresh_kind;
      job.cp        = (fresh_kind == FK_CP) ? {13'd0, in_byte} : REPL_CP;
      if (fresh_open) begin
        held_lead_next  = in_byte;
        held_count_next = '0;
        seq_active_next = 1'b1;
      end else begin
        held_lead_next  = '0;
        held_count_next = '0;
        seq_active_next = 1'b0;
      end
    end
  end

  assign push     = take && (job.kind != FK_NONE || job.flush_cnt != 2'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      bmp_only   <= 1'b1;
      held_lead  <= '0;
      held_count <= '0;
      seq_active <= 1'b0;
    end else begin
      if (cfg_wr) begin
        bmp_only <= cfg_data;
      end
      if (take) begin
        held_lead  <= held_lead_next;
        held_count <= held_count_next;
        seq_active <= seq_active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cont_wr) begin
      held_cont[held_count[0]] <= in_byte;
    end
  end

`include "utf8_code_point_decoder_core_defines.svh"

  `UTFD_ASSERT_NOW(a_idle_holds_nothing, !seq_active, held_count == 2'd0, "count while idle")
  `UTFD_ASSERT_NOW(a_count_bound, seq_active, held_count != 2'd3, "too many held bytes")

endmodule

// ----- design/utfd_queue.sv -----
module utfd_queue
  import utfd_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  utfd_job_t push_job,
  output logic      full,
  input  logic      pop,
  output utfd_job_t pop_job,
  output logic      empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utfd_job_t       mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

`include "utf8_code_point_decoder_core_defines.svh"

  `UTFD_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
  `UTFD_ASSERT_NOW(a_count_range, 1'b1, count <= CntW'(Depth), "queue count out of range")

endmodule

// ----- design/utfd_back.sv -----
module utfd_back
  import utfd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  utfd_job_t       pop_job,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [CP_W-1:0] code_point,
  output logic            decode_error,
  output logic            end_of_string,
  output logic            last_in_run
);

  utfd_job_t  cur;
  logic       cur_valid;
  logic [1:0] step;

  logic on_final;
  logic done;
  logic load;

  assign on_final = (step == cur.flush_cnt);
  assign last_in_run = (cur.kind == FK_NONE) ? (step == 2'(cur.flush_cnt - 2'd1))
                                             : on_final;

  assign result_valid  = cur_valid;
  assign code_point    = on_final ? cur.cp : REPL_CP;
  assign decode_error  = on_final ? (cur.kind == FK_ERR) : 1'b1;
  assign end_of_string = on_final && (cur.kind == FK_EOS);

  assign done = result_valid && result_ready && last_in_run;
  assign load = !cur_valid || done;
  assign pop  = load && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      cur_valid <= !empty;
      step      <= '0;
    end else if (result_valid && result_ready) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_job;
    end
  end

`include "utf8_code_point_decoder_core_defines.svh"

  `UTFD_ASSERT_NOW(a_step_bound, cur_valid, step <= cur.flush_cnt, "step past job end")
  `UTFD_ASSERT_NOW(a_job_nonempty, cur_valid,
    cur.kind != FK_NONE || cur.flush_cnt != 2'd0, "empty job loaded")

endmodule
